// ===== rtl/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 byte stream decoder.
package utf8d_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 2;

  // Keep-ASCII register value after reset.
  localparam logic KEEP_ASCII_RST = 1'b0;

  // Lead byte test bits and payload masks.
  localparam logic [BYTE_W-1:0] LEAD_BIT     = 8'h80;
  localparam logic [BYTE_W-1:0] TWO_TEST     = 8'h20;
  localparam logic [BYTE_W-1:0] THREE_TEST   = 8'h10;
  localparam logic [BYTE_W-1:0] FOUR_TEST    = 8'h08;
  localparam logic [BYTE_W-1:0] TWO_PAYLOAD  = 8'h1F;
  localparam logic [BYTE_W-1:0] THREE_PAYLOAD = 8'h0F;
  localparam logic [BYTE_W-1:0] FOUR_PAYLOAD = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_PAYLOAD = 8'h3F;

  // Continuation bytes due after each lead class.
  localparam logic [1:0] REM_TWO   = 2'd1;
  localparam logic [1:0] REM_THREE = 2'd2;
  localparam logic [1:0] REM_FOUR  = 2'd3;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            has_code;
    logic            decode_error;
    logic            string_done;
  } utf8d_res_t;

endpackage

// ===== rtl/utf8d_decode.sv =====
// Decode state and per-byte next-state / result logic.
module utf8d_decode
  import utf8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              end_of_string,
  input  logic              keep_ascii,
  output logic              res_valid,
  output utf8d_res_t        res
);

  logic [CP_W-1:0] partial_r, partial_nxt;
  logic [1:0]      rem_r, rem_nxt;
  logic            drop_r, drop_nxt;

  logic            have;
  logic [CP_W-1:0] cp;
  logic            err;
  logic [CP_W-1:0] shifted;

  assign shifted = {partial_r[CP_W-7:0], data_byte[5:0] & CONT_PAYLOAD[5:0]};

  always_comb begin
    partial_nxt = partial_r;
    rem_nxt     = rem_r;
    drop_nxt    = drop_r;
    have        = 1'b0;
    cp          = '0;
    err         = 1'b0;

    priority if (drop_r) begin
      // hold until final byte
    end else if (rem_r != 2'd0) begin
      rem_nxt = rem_r - 2'd1;
      if (rem_r == 2'd1) begin
        have        = 1'b1;
        cp          = shifted;
        partial_nxt = '0;
      end else begin
        partial_nxt = shifted;
      end
    end else if ((data_byte & LEAD_BIT) == '0) begin
      if (keep_ascii) begin
        have = 1'b1;
        cp   = {{(CP_W-BYTE_W){1'b0}}, data_byte};
      end
    end else if ((data_byte & TWO_TEST) == '0) begin
      partial_nxt = {{(CP_W-BYTE_W){1'b0}}, data_byte & TWO_PAYLOAD};
      rem_nxt     = REM_TWO;
    end else if ((data_byte & THREE_TEST) == '0) begin
      partial_nxt = {{(CP_W-BYTE_W){1'b0}}, data_byte & THREE_PAYLOAD};
      rem_nxt     = REM_THREE;
    end else if ((data_byte & FOUR_TEST) == '0) begin
      partial_nxt = {{(CP_W-BYTE_W){1'b0}}, data_byte & FOUR_PAYLOAD};
      rem_nxt     = REM_FOUR;
    end else begin
      drop_nxt    = 1'b1;
      partial_nxt = '0;
      rem_nxt     = 2'd0;
    end

    if (end_of_string) begin
      err = drop_nxt || (rem_nxt != 2'd0);
      if (err) begin
        have = 1'b0;
        cp   = '0;
      end
      partial_nxt = '0;
      rem_nxt     = 2'd0;
      drop_nxt    = 1'b0;
    end
  end

  assign res_valid        = have || end_of_string;
  assign res.code_point   = cp;
  assign res.has_code     = have;
  assign res.decode_error = err;
  assign res.string_done  = end_of_string;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      rem_r     <= 2'd0;
      drop_r    <= 1'b0;
    end else if (advance) begin
      partial_r <= partial_nxt;
      rem_r     <= rem_nxt;
      drop_r    <= drop_nxt;
    end
  end

endmodule

// ===== rtl/utf8d_out_reg.sv =====
// Result register with ready/valid handshake toward the output stream.
module utf8d_out_reg
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  utf8d_res_t load_res,
  output logic       busy,
  input  logic       out_tready,
  output logic       out_tvalid,
  output utf8d_res_t out_res
);

  logic       vld_r, vld_nxt;
  utf8d_res_t res_r;

  // slot is occupied and not draining this cycle
  assign busy    = vld_r && !out_tready;
  assign vld_nxt = busy || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_res    = res_r;

endmodule

// ===== rtl/utf8_byte_stream_decoder.sv =====
// Top level of the UTF-8 byte stream decoder.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------------
//  in_     | in  | in_tvalid / in_tready | tdata: data_byte; tlast: end_of_string
//  out_    | out | out_tvalid/out_tready | tdata: code_point; tuser: has_code,
//          |     |                       |   decode_error; tlast: string_done
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_data: keep_ascii
//
// One item per cycle sustained while the output is not stalled; an accepted byte is
// held in the input register and decoded into the result register when it advances.
// A stalled result blocks the decode stage only when the next byte also yields
// a result; bytes that yield nothing keep flowing past a full result register.
// Synchronous active-low reset clears decode state, valids and keep_ascii.
// cfg_ready is always high; write it only while the block is idle.
module utf8_byte_stream_decoder
  import utf8d_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input byte stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // end_of_string
  // decoded results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [0] has_code, [1] decode_error
  output logic                   out_tlast,  // string_done
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data    // keep_ascii
);

  // input register
  logic              in_vld_r, in_vld_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              eos_r;

  logic       keep_ascii_r;
  logic       advance;
  logic       res_valid;
  logic       out_busy;
  utf8d_res_t res;
  utf8d_res_t out_res;

  // a byte leaves the input register unless its result has nowhere to go
  assign advance    = in_vld_r && !(res_valid && out_busy);
  assign in_tready  = !in_vld_r || advance;
  assign in_vld_nxt = (in_tvalid && in_tready) || (in_vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      eos_r  <= in_tlast;
    end
  end

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_ascii_r <= KEEP_ASCII_RST;
    end else if (cfg_valid && cfg_ready) begin
      keep_ascii_r <= cfg_data;
    end
  end

  utf8d_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .data_byte     (byte_r),
    .end_of_string (eos_r),
    .keep_ascii    (keep_ascii_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  utf8d_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && res_valid),
    .load_res   (res),
    .busy       (out_busy),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res)
  );

  assign out_tdata = {{(OUT_TDATA_W-CP_W){1'b0}}, out_res.code_point};
  assign out_tuser = {out_res.decode_error, out_res.has_code};
  assign out_tlast = out_res.string_done;

endmodule

// ===== rtl/utf8d_checker.sv =====
// Port-level checks for the UTF-8 byte stream decoder, bound to the top level.
module utf8d_checker
  import utf8d_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser,
  input logic                   out_tlast
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  // error flag appears only on the end-of-string result
  a_err_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0])
    else $error("decode error outside end result or with code");

  // mid-string results always carry a code point
  a_mid_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser[0])
    else $error("empty result before end of string");

  // no code means zero data
  a_no_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("nonzero data without code point");

endmodule

bind utf8_byte_stream_decoder utf8d_checker u_chk (.*);
